@@ hw/rtl/lzw_st_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the LZW string table.
// No dependencies; imported by every module of the block.
package lzw_st_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int MAX_LEN_DEF     = 64;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int CODE_W = 12;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 2;

  // Depth of the command and result queues (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_NEW    = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTEND = 2'd1;
  localparam logic [OP_W-1:0] OP_SUFFIX = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_LONG     = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNFILLED = 2'd3;

  // One command waiting for the engine
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] value;
    logic              emits;  // command produces at least one result beat
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [CODE_W-1:0] new_code;
    logic              last;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

@@ hw/rtl/lzw_string_table.sv @@
`timescale 1ns / 1ps
// Top level of the LZW string table: command queue, engine, result queue.
// Depends on lzw_st_pkg, lzw_st_front, lzw_st_engine, lzw_st_resq.
//
// LZW dictionary with queue-style ports on both sides. Commands wait in a
// four-deep queue; results leave through a four-deep queue, so either side
// may stall independently. The engine handles one command at a time. New,
// extend and suffix commands pass through the engine as a memory read, then
// a decide-and-write step. A read of a string of length L walks the prefix
// chain one entry per cycle through the single read port of the dictionary
// memories; the bytes land in a reversal buffer, then they are emitted first
// to last at one beat per cycle while the result queue has room. Codes are
// handed out from 0 upward; the dictionary needs no clearing after reset
// and accepts commands in the first cycle after reset is released.
module lzw_string_table #(
  parameter int TABLE_DEPTH = lzw_st_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_LEN     = lzw_st_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [lzw_st_pkg::OP_W-1:0]   in_op,
  input  logic [lzw_st_pkg::CODE_W-1:0] in_code,
  input  logic [lzw_st_pkg::BYTE_W-1:0] in_value,
  output logic                          empty,
  input  logic                          pop,
  output logic [lzw_st_pkg::BYTE_W-1:0] out_data_byte,
  output logic [lzw_st_pkg::CODE_W-1:0] out_new_code,
  output logic                          out_last,
  output logic [lzw_st_pkg::STAT_W-1:0] out_status
);
  import lzw_st_pkg::*;

  localparam int FW = $clog2(TABLE_DEPTH) + 1;

  logic          cmd_empty;
  logic          cmd_pop;
  cmd_t          cmd_head;
  logic          res_full;
  logic          res_push;
  res_t          res_beat;
  logic [FW-1:0] fill_count;

  lzw_st_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_op     (in_op),
    .in_code   (in_code),
    .in_value  (in_value),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_head  (cmd_head)
  );

  lzw_st_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_LEN     (MAX_LEN)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .cmd_head   (cmd_head),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_beat   (res_beat),
    .fill_count (fill_count)
  );

  lzw_st_resq u_resq (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_push      (res_push),
    .res_beat      (res_beat),
    .res_full      (res_full),
    .empty         (empty),
    .pop           (pop),
    .out_data_byte (out_data_byte),
    .out_new_code  (out_new_code),
    .out_last      (out_last),
    .out_status    (out_status)
  );

  // Fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count <= FW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // Fill count only ever steps up by one
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && fill_count != $past(fill_count))
      |-> fill_count == FW'($past(fill_count) + 1'b1))
    else $error("fill count jumped");

  // Engine never pushes a beat into a full result queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("result beat pushed while queue full");

  // Error beats end their command and carry no code
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_beat.status != ST_OK)
      |-> (res_beat.last && res_beat.new_code == '0 && res_beat.data_byte == '0))
    else $error("malformed error beat");

  // A suffix command never produces a beat of its own
  a_sfx_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && !cmd_empty && !cmd_head.emits) |=> !res_push)
    else $error("beat produced for suffix command");

endmodule

@@ hw/rtl/lzw_st_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input beats, tags them and queues them as commands.
// Depends on lzw_st_pkg.
module lzw_st_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [lzw_st_pkg::OP_W-1:0]   in_op,
  input  logic [lzw_st_pkg::CODE_W-1:0] in_code,
  input  logic [lzw_st_pkg::BYTE_W-1:0] in_value,
  output logic                          cmd_empty,
  input  logic                          cmd_pop,
  output lzw_st_pkg::cmd_t              cmd_head
);
  import lzw_st_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);

  cmd_t           q_mem [QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_r;
  logic [QW-1:0]  rd_ptr_r;
  logic [QW:0]    cnt_r;
  logic           accept;
  logic           take;
  cmd_t           cmd_in;

  assign full      = (cnt_r == (QW+1)'(QUEUE_DEPTH));
  assign cmd_empty = (cnt_r == '0);
  assign accept    = push && !full;
  assign take      = cmd_pop && !cmd_empty;
  assign cmd_head  = q_mem[rd_ptr_r];

  // Classify: only a suffix update is silent
  always_comb begin
    cmd_in.op    = in_op;
    cmd_in.code  = in_code;
    cmd_in.value = in_value;
    cmd_in.emits = (in_op != OP_SUFFIX);
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) wr_ptr_r <= QW'(wr_ptr_r + 1'b1);
      if (take)   rd_ptr_r <= QW'(rd_ptr_r + 1'b1);
      if (accept && !take)      cnt_r <= (QW+1)'(cnt_r + 1'b1);
      else if (take && !accept) cnt_r <= (QW+1)'(cnt_r - 1'b1);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) q_mem[wr_ptr_r] <= cmd_in;
  end

endmodule

@@ hw/rtl/lzw_st_engine.sv @@
`timescale 1ns / 1ps
// Back end: dictionary memories, fill count, chain walker and byte reversal.
// Depends on lzw_st_pkg.
module lzw_st_engine #(
  parameter int TABLE_DEPTH = lzw_st_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_LEN     = lzw_st_pkg::MAX_LEN_DEF,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int FW = AW + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  input  lzw_st_pkg::cmd_t cmd_head,
  input  logic             res_full,
  output logic             res_push,
  output lzw_st_pkg::res_t res_beat,
  output logic [FW-1:0]    fill_count
);
  import lzw_st_pkg::*;

  localparam int RW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = (FW > CODE_W) ? FW : CODE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_PRIME = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // Dictionary and reversal memories
  logic [AW-1:0]     pl_mem  [TABLE_DEPTH];
  logic [BYTE_W-1:0] lb_mem  [TABLE_DEPTH];
  logic [LEN_W-1:0]  len_mem [TABLE_DEPTH];
  logic [BYTE_W-1:0] rev_mem [MAX_LEN];

  logic [AW-1:0]     pl_rd_r;
  logic [BYTE_W-1:0] lb_rd_r;
  logic [LEN_W-1:0]  len_rd_r;
  logic [BYTE_W-1:0] rev_rd_r;

  // Control and command registers
  logic [2:0]        st_r,     st_nxt;
  logic [FW-1:0]     fill_r,   fill_nxt;
  logic [OP_W-1:0]   op_r,     op_nxt;
  logic [CODE_W-1:0] code_r,   code_nxt;
  logic [BYTE_W-1:0] value_r,  value_nxt;
  logic              filled_r, filled_nxt;
  logic [LEN_W-1:0]  cnt_r,    cnt_nxt;
  logic [LEN_W-1:0]  len_r,    len_nxt;
  logic [LEN_W-1:0]  j_r,      j_nxt;

  // Memory port controls
  logic [AW-1:0]     rd_addr;
  logic              ent_we;
  logic              sfx_we;
  logic [AW-1:0]     ent_wa;
  logic [AW-1:0]     pl_wd;
  logic [BYTE_W-1:0] lb_wd;
  logic [LEN_W-1:0]  len_wd;
  logic              rev_we;
  logic [RW-1:0]     rev_wa;
  logic [RW-1:0]     rev_ra;

  logic              tbl_full;
  logic [LEN_W-1:0]  walk_len;
  logic              emit_last;

  assign fill_count = fill_r;
  assign tbl_full   = (fill_r >= FW'(TABLE_DEPTH));
  assign ent_wa     = AW'(fill_r);
  assign emit_last  = (j_r == LEN_W'(len_r - 1'b1));

  // Stored lengths are 1..MAX_LEN; clamp anyway
  always_comb begin
    if (len_rd_r == '0)                       walk_len = LEN_W'(1);
    else if (len_rd_r > LEN_W'(MAX_LEN))      walk_len = LEN_W'(MAX_LEN);
    else                                      walk_len = len_rd_r;
  end

  // Read address: incoming code, held code, or the chain link just read
  always_comb begin
    case (st_r)
      S_IDLE:  rd_addr = AW'(cmd_head.code);
      S_WALK:  rd_addr = pl_rd_r;
      default: rd_addr = AW'(code_r);
    endcase
  end

  // Sequencer
  always_comb begin
    st_nxt     = st_r;
    fill_nxt   = fill_r;
    op_nxt     = op_r;
    code_nxt   = code_r;
    value_nxt  = value_r;
    filled_nxt = filled_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    j_nxt      = j_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_beat   = '0;
    ent_we     = 1'b0;
    sfx_we     = 1'b0;
    pl_wd      = '0;
    lb_wd      = value_r;
    len_wd     = LEN_W'(1);
    rev_we     = 1'b0;
    rev_wa     = RW'(cnt_r - 1'b1);
    rev_ra     = RW'(j_r);

    case (st_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          op_nxt     = cmd_head.op;
          code_nxt   = cmd_head.code;
          value_nxt  = cmd_head.value;
          filled_nxt = (CW'(cmd_head.code) < CW'(fill_r));
          st_nxt     = S_EXEC;
        end
      end

      S_EXEC: begin
        if (op_r == OP_SUFFIX) begin
          sfx_we = filled_r;
          st_nxt = S_IDLE;
        end else if (op_r == OP_READ && filled_r) begin
          cnt_nxt = walk_len;
          len_nxt = walk_len;
          st_nxt  = S_WALK;
        end else if (!res_full) begin
          // Single-beat outcome of new, extend, or a bad read
          res_push      = 1'b1;
          res_beat.last = 1'b1;
          st_nxt        = S_IDLE;
          if (op_r != OP_NEW && !filled_r) begin
            res_beat.status = ST_UNFILLED;
          end else if (tbl_full) begin
            res_beat.status = ST_FULL;
          end else if (op_r == OP_EXTEND && len_rd_r >= LEN_W'(MAX_LEN)) begin
            res_beat.status = ST_LONG;
          end else begin
            ent_we            = 1'b1;
            res_beat.new_code = CODE_W'(fill_r);
            fill_nxt          = FW'(fill_r + 1'b1);
            if (op_r == OP_NEW) begin
              pl_wd  = '0;
              lb_wd  = value_r;
              len_wd = LEN_W'(1);
            end else begin
              pl_wd  = AW'(code_r);
              lb_wd  = '0;
              len_wd = LEN_W'(len_rd_r + 1'b1);
            end
          end
        end
      end

      // One chain entry per cycle, stored last byte first
      S_WALK: begin
        rev_we  = 1'b1;
        cnt_nxt = LEN_W'(cnt_r - 1'b1);
        if (cnt_r == LEN_W'(1)) st_nxt = S_PRIME;
      end

      S_PRIME: begin
        rev_ra = '0;
        j_nxt  = '0;
        st_nxt = S_EMIT;
      end

      // Emit one byte per cycle while the result queue has room, reading one ahead
      S_EMIT: begin
        if (!res_full) begin
          res_push           = 1'b1;
          res_beat.data_byte = rev_rd_r;
          res_beat.last      = emit_last;
          res_beat.status    = ST_OK;
          rev_ra             = RW'(j_r + 1'b1);
          j_nxt              = LEN_W'(j_r + 1'b1);
          if (emit_last) st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      fill_r <= '0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Command and counter registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    code_r   <= code_nxt;
    value_r  <= value_nxt;
    filled_r <= filled_nxt;
    cnt_r    <= cnt_nxt;
    len_r    <= len_nxt;
    j_r      <= j_nxt;
  end

  // Prefix link memory
  always_ff @(posedge clk) begin
    if (ent_we) pl_mem[ent_wa] <= pl_wd;
    pl_rd_r <= pl_mem[rd_addr];
  end

  // Last byte memory; suffix writes go to the named code
  always_ff @(posedge clk) begin
    if (ent_we)      lb_mem[ent_wa]       <= lb_wd;
    else if (sfx_we) lb_mem[AW'(code_r)]  <= value_r;
    lb_rd_r <= lb_mem[rd_addr];
  end

  // String length memory
  always_ff @(posedge clk) begin
    if (ent_we) len_mem[ent_wa] <= len_wd;
    len_rd_r <= len_mem[rd_addr];
  end

  // Reversal buffer
  always_ff @(posedge clk) begin
    if (rev_we) rev_mem[rev_wa] <= lb_rd_r;
    rev_rd_r <= rev_mem[rev_ra];
  end

endmodule

@@ hw/rtl/lzw_st_resq.sv @@
`timescale 1ns / 1ps
// Result queue between the engine and the output ports.
// Depends on lzw_st_pkg.
module lzw_st_resq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_push,
  input  lzw_st_pkg::res_t              res_beat,
  output logic                          res_full,
  output logic                          empty,
  input  logic                          pop,
  output logic [lzw_st_pkg::BYTE_W-1:0] out_data_byte,
  output logic [lzw_st_pkg::CODE_W-1:0] out_new_code,
  output logic                          out_last,
  output logic [lzw_st_pkg::STAT_W-1:0] out_status
);
  import lzw_st_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);

  res_t          q_mem [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r;
  logic [QW-1:0] rd_ptr_r;
  logic [QW:0]   cnt_r;
  logic          take;
  logic          put;
  res_t          head;

  assign res_full = (cnt_r == (QW+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign put      = res_push && !res_full;
  assign take     = pop && !empty;
  assign head     = q_mem[rd_ptr_r];

  assign out_data_byte = head.data_byte;
  assign out_new_code  = head.new_code;
  assign out_last      = head.last;
  assign out_status    = head.status;

  // Pointers and level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (put)  wr_ptr_r <= QW'(wr_ptr_r + 1'b1);
      if (take) rd_ptr_r <= QW'(rd_ptr_r + 1'b1);
      if (put && !take)      cnt_r <= (QW+1)'(cnt_r + 1'b1);
      else if (take && !put) cnt_r <= (QW+1)'(cnt_r - 1'b1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (put) q_mem[wr_ptr_r] <= res_beat;
  end

endmodule

@@ tb/lzw_table_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the LZW string table: watches command and result beats,
// keeps its own copy of the dictionary and compares every result beat.
// Depends on lzw_st_pkg for field widths, operation and status codes.
module lzw_table_checker #(
  parameter int TABLE_DEPTH = lzw_st_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_LEN     = lzw_st_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          full,
  input  logic [lzw_st_pkg::OP_W-1:0]   in_op,
  input  logic [lzw_st_pkg::CODE_W-1:0] in_code,
  input  logic [lzw_st_pkg::BYTE_W-1:0] in_value,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [lzw_st_pkg::BYTE_W-1:0] out_data_byte,
  input  logic [lzw_st_pkg::CODE_W-1:0] out_new_code,
  input  logic                          out_last,
  input  logic [lzw_st_pkg::STAT_W-1:0] out_status,
  output int                            fail_count,
  output int                            beats_waiting,
  output int                            beats_checked
);
  import lzw_st_pkg::*;

  // Shadow dictionary
  logic [CODE_W-1:0] chain_link [TABLE_DEPTH];
  logic [BYTE_W-1:0] tail_byte  [TABLE_DEPTH];
  logic [LEN_W-1:0]  str_len    [TABLE_DEPTH];
  logic [BYTE_W-1:0] byte_stack [MAX_LEN];
  int                entries_used;

  // Result beats still owed by the block, oldest first
  res_t expected_beats [$];

  res_t  got_beat, want_beat;
  string diffs;
  int    n_checked;

  initial begin
    fail_count    = 0;
    beats_waiting = 0;
    beats_checked = 0;
    n_checked     = 0;
    entries_used  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic res_t make_beat(input logic [BYTE_W-1:0] b, input logic [CODE_W-1:0] c,
                                     input logic l, input logic [STAT_W-1:0] s);
    res_t r;
    r.data_byte = b;
    r.new_code  = c;
    r.last      = l;
    r.status    = s;
    return r;
  endfunction

  // Work out the beats one accepted command produces and update the shadow table
  task automatic predict_dictionary_op(input logic [OP_W-1:0] op,
                                       input logic [CODE_W-1:0] code,
                                       input logic [BYTE_W-1:0] val);
    bit filled;
    int n_len;
    int idx;
    filled = (int'(code) < entries_used) && (int'(code) < TABLE_DEPTH);
    case (op)
      OP_NEW: begin
        if (entries_used >= TABLE_DEPTH) begin
          expected_beats.push_back(make_beat('0, '0, 1'b1, ST_FULL));
        end else begin
          chain_link[entries_used] = '0;
          tail_byte[entries_used]  = val;
          str_len[entries_used]    = LEN_W'(1);
          expected_beats.push_back(make_beat('0, CODE_W'(entries_used), 1'b1, ST_OK));
          entries_used++;
        end
      end
      OP_EXTEND: begin
        // unfilled code wins over table full, which wins over too long
        if (!filled) begin
          expected_beats.push_back(make_beat('0, '0, 1'b1, ST_UNFILLED));
        end else if (entries_used >= TABLE_DEPTH) begin
          expected_beats.push_back(make_beat('0, '0, 1'b1, ST_FULL));
        end else if (int'(str_len[code]) >= MAX_LEN) begin
          expected_beats.push_back(make_beat('0, '0, 1'b1, ST_LONG));
        end else begin
          chain_link[entries_used] = code;
          tail_byte[entries_used]  = '0;
          str_len[entries_used]    = str_len[code] + LEN_W'(1);
          expected_beats.push_back(make_beat('0, CODE_W'(entries_used), 1'b1, ST_OK));
          entries_used++;
        end
      end
      OP_SUFFIX: begin
        // no beat; ignored on an unfilled code
        if (filled) tail_byte[code] = val;
      end
      default: begin
        if (!filled) begin
          expected_beats.push_back(make_beat('0, '0, 1'b1, ST_UNFILLED));
        end else begin
          n_len = int'(str_len[code]);
          if (n_len > MAX_LEN) n_len = MAX_LEN;
          if (n_len == 0) n_len = 1;
          // gather last byte first along the prefix links
          idx = int'(code);
          for (int i = n_len; i > 0; i--) begin
            if (idx >= TABLE_DEPTH) idx = 0;
            byte_stack[i-1] = tail_byte[idx];
            idx = int'(chain_link[idx]);
          end
          for (int i = 0; i < n_len; i++)
            expected_beats.push_back(make_beat(byte_stack[i], '0, (i + 1 == n_len), ST_OK));
        end
      end
    endcase
  endtask

  // Compare result beats, then predict from command beats
  always @(posedge clk) begin
    if (!rst_n) begin
      entries_used = 0;
      expected_beats.delete();
    end else begin
      if (pop && !empty) begin
        got_beat.data_byte = out_data_byte;
        got_beat.new_code  = out_new_code;
        got_beat.last      = out_last;
        got_beat.status    = out_status;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: byte %h code %h last %b status %0d",
                                    out_data_byte, out_new_code, out_last, out_status));
        end else begin
          want_beat = expected_beats.pop_front();
          diffs = "";
          if (got_beat.data_byte != want_beat.data_byte)
            diffs = {diffs, $sformatf(" data_byte %h/%h", got_beat.data_byte,
                                      want_beat.data_byte)};
          if (got_beat.new_code != want_beat.new_code)
            diffs = {diffs, $sformatf(" new_code %h/%h", got_beat.new_code,
                                      want_beat.new_code)};
          if (got_beat.last != want_beat.last)
            diffs = {diffs, $sformatf(" last %b/%b", got_beat.last, want_beat.last)};
          if (got_beat.status != want_beat.status)
            diffs = {diffs, $sformatf(" status %0d/%0d", got_beat.status, want_beat.status)};
          if (diffs != "")
            report_mismatch($sformatf("beat %0d (got/want):%s", n_checked, diffs));
        end
        n_checked++;
      end
      if (push && !full) predict_dictionary_op(in_op, in_code, in_value);
    end
    beats_waiting <= expected_beats.size();
    beats_checked <= n_checked;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the LZW string table testbench: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on lzw_st_pkg,
// lzw_string_table and lzw_table_checker.
module tb_top;
  import lzw_st_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int MAX_LEN     = MAX_LEN_DEF;
  localparam int RANDOM_CMDS = 64;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              push;
  logic              full;
  logic [OP_W-1:0]   in_op;
  logic [CODE_W-1:0] in_code;
  logic [BYTE_W-1:0] in_value;
  logic              empty;
  logic              pop;
  logic [BYTE_W-1:0] out_data_byte;
  logic [CODE_W-1:0] out_new_code;
  logic              out_last;
  logic [STAT_W-1:0] out_status;

  int fail_count, beats_waiting, beats_checked;

  // Idle percentages of sender and receiver
  int send_idle = 0;
  int recv_idle = 0;

  // Generator bookkeeping: entries handed out and their lengths
  int gen_fill = 0;
  int gen_len [TABLE_DEPTH];
  int cmd_count = 0;
  int directed_cmds, random_cmds, long_cmds;
  int r;
  logic [CODE_W-1:0] tip, long_tip;

  lzw_string_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_LEN     (MAX_LEN)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_op         (in_op),
    .in_code       (in_code),
    .in_value      (in_value),
    .empty         (empty),
    .pop           (pop),
    .out_data_byte (out_data_byte),
    .out_new_code  (out_new_code),
    .out_last      (out_last),
    .out_status    (out_status)
  );

  lzw_table_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_LEN     (MAX_LEN)
  ) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_op         (in_op),
    .in_code       (in_code),
    .in_value      (in_value),
    .empty         (empty),
    .pop           (pop),
    .out_data_byte (out_data_byte),
    .out_new_code  (out_new_code),
    .out_last      (out_last),
    .out_status    (out_status),
    .fail_count    (fail_count),
    .beats_waiting (beats_waiting),
    .beats_checked (beats_checked)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Run limit for a hung run
  initial begin
    #(2_000_000);
    $display("lzw_string_table test failed");
    $finish;
  end

  task automatic set_idle(input int s, input int rcv);
    send_idle <= s;
    recv_idle <= rcv;
  endtask

  // One command beat, with random sender gaps ahead of it
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                          input logic [BYTE_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    in_op    <= op;
    in_code  <= code;
    in_value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    cmd_count++;
    if (op == OP_NEW && gen_fill < TABLE_DEPTH) begin
      gen_len[gen_fill] = 1;
      gen_fill++;
    end else if (op == OP_EXTEND && int'(code) < gen_fill && gen_fill < TABLE_DEPTH &&
                 gen_len[code] < MAX_LEN) begin
      gen_len[gen_fill] = gen_len[code] + 1;
      gen_fill++;
    end
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    if (gen_fill == 0) return '0;
    return CODE_W'($urandom_range(0, gen_fill - 1));
  endfunction

  // New one-byte entry followed by a run of extensions, some given a suffix
  task automatic grow_chain(input int extra, input int sfx_pct,
                            output logic [CODE_W-1:0] chain_tip);
    send_cmd(OP_NEW, CODE_W'($urandom), BYTE_W'($urandom));
    chain_tip = CODE_W'(gen_fill - 1);
    for (int i = 0; i < extra; i++) begin
      send_cmd(OP_EXTEND, chain_tip, BYTE_W'($urandom));
      chain_tip = CODE_W'(gen_fill - 1);
      if ($urandom_range(0, 99) < sfx_pct) send_cmd(OP_SUFFIX, chain_tip, BYTE_W'($urandom));
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    push     <= 1'b0;
    in_op    <= OP_NEW;
    in_code  <= '0;
    in_value <= '0;
    set_idle(13, 47);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, byte extremes, suffix before and after set,
    // unfilled codes on read, extend and suffix
    send_cmd(OP_READ,   12'd0,    8'h00);
    send_cmd(OP_EXTEND, 12'd0,    8'h00);
    send_cmd(OP_SUFFIX, 12'd0,    8'hFF);
    send_cmd(OP_NEW,    12'hFFF,  8'h00);
    send_cmd(OP_NEW,    12'd0,    8'hFF);
    send_cmd(OP_READ,   12'd0,    8'h00);
    send_cmd(OP_READ,   12'd1,    8'hFF);
    send_cmd(OP_EXTEND, 12'd1,    8'h00);
    send_cmd(OP_READ,   12'd2,    8'h00);
    send_cmd(OP_SUFFIX, 12'd2,    8'hA5);
    send_cmd(OP_READ,   12'd2,    8'h00);
    send_cmd(OP_EXTEND, 12'd2,    8'hFF);
    send_cmd(OP_SUFFIX, 12'd3,    8'h5A);
    send_cmd(OP_READ,   12'd3,    8'h00);
    send_cmd(OP_EXTEND, 12'hFFF,  8'h00);
    send_cmd(OP_READ,   12'd4,    8'h00);
    send_cmd(OP_EXTEND, 12'd4,    8'h00);
    send_cmd(OP_SUFFIX, 12'hFFF,  8'h00);
    send_cmd(OP_SUFFIX, 12'd0,    8'h80);
    send_cmd(OP_READ,   12'd0,    8'h00);
    send_cmd(OP_READ,   12'hFFF,  8'hFF);
    directed_cmds = cmd_count;

    // Random: mostly chains built then read back, some reads and suffix
    // writes on old entries, and some noise; idling swaps sides halfway
    while (cmd_count - directed_cmds < RANDOM_CMDS) begin
      if (cmd_count - directed_cmds >= RANDOM_CMDS / 2) set_idle(47, 13);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        grow_chain($urandom_range(0, 5), 75, tip);
        send_cmd(OP_READ, tip, BYTE_W'($urandom));
      end else if (r < 70) begin
        send_cmd(OP_READ, pick_code(), BYTE_W'($urandom));
      end else if (r < 80) begin
        send_cmd(OP_SUFFIX, pick_code(), BYTE_W'($urandom));
      end else begin
        send_cmd(OP_W'($urandom), CODE_W'($urandom), BYTE_W'($urandom));
      end
    end
    random_cmds = cmd_count - directed_cmds;

    // Longest string with no idling: build to the length limit, overrun it,
    // read it all, then touch both ends of the table
    set_idle(0, 0);
    grow_chain(MAX_LEN - 1, 10, long_tip);
    send_cmd(OP_EXTEND, long_tip, BYTE_W'($urandom));
    send_cmd(OP_READ,   long_tip, BYTE_W'($urandom));
    send_cmd(OP_SUFFIX, 12'hFFF, 8'hFF);
    send_cmd(OP_READ,   12'hFFF, 8'h00);
    send_cmd(OP_READ,   12'd0,   8'h00);
    long_cmds = cmd_count - directed_cmds - random_cmds;
    push <= 1'b0;

    // Drain, then allow for a longest read still in flight
    while (beats_waiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d commands: %0d directed, %0d random, %0d around the longest string",
             cmd_count, directed_cmds, random_cmds, long_cmds);
    $display("Checked %0d result beats; table reached %0d of %0d entries",
             beats_checked, gen_fill, TABLE_DEPTH);
    if (fail_count == 0 && beats_waiting == 0) begin
      $display("lzw_string_table test passed");
    end else begin
      $display("lzw_string_table test failed");
    end
    $finish;
  end

endmodule
